FILE: hdl/imh_pkg.sv
// ----------------------------------------------------------------------------
// imh_pkg
// Shared codes for the indexed min-heap: request actions and result status.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned VERTEX_W = 10;
  localparam int unsigned DISTREQ_W = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W = 11;

  localparam logic [ACTION_W-1:0] ACT_INSERT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_EXTRACT  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DECREASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd4;

endpackage

FILE: hdl/imh_req_if.sv
// ----------------------------------------------------------------------------
// imh_req_if
// Request channel: one word per heap operation.
// ----------------------------------------------------------------------------
interface imh_req_if
  import imh_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [VERTEX_W-1:0]  vertex;
  logic [DISTREQ_W-1:0] dist_req;

  modport source (output valid, action, vertex, dist_req, input ready);
  modport sink   (input valid, action, vertex, dist_req, output ready);
endinterface

FILE: hdl/imh_rsp_if.sv
// ----------------------------------------------------------------------------
// imh_rsp_if
// Result channel: one word per heap operation.
// ----------------------------------------------------------------------------
interface imh_rsp_if
  import imh_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [VERTEX_W-1:0]  min_vertex;
  logic [DISTREQ_W-1:0] min_dist;
  logic [COUNT_W-1:0]   count;
  logic                 is_empty;

  modport source (output valid, status, min_vertex, min_dist, count, is_empty, input ready);
  modport sink   (input valid, status, min_vertex, min_dist, count, is_empty, output ready);
endinterface

FILE: hdl/imh_slot_ram.sv
// ----------------------------------------------------------------------------
// imh_slot_ram
// Heap slot store (vertex, distance): one write port, two registered reads.
// ----------------------------------------------------------------------------
module imh_slot_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned VW    = 10,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [VW-1:0] wvert_i,
  input  logic [DW-1:0] wdist_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [VW-1:0] rvert_a_o,
  output logic [DW-1:0] rdist_a_o,
  output logic [VW-1:0] rvert_b_o,
  output logic [DW-1:0] rdist_b_o
);

  logic [VW+DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wvert_i, wdist_i};
    end
    {rvert_a_o, rdist_a_o} <= mem[raddr_a_i];
    {rvert_b_o, rdist_b_o} <= mem[raddr_b_i];
  end

endmodule

FILE: hdl/imh_pos_ram.sv
// ----------------------------------------------------------------------------
// imh_pos_ram
// Per-vertex slot index and presence bit: one write, one registered read.
// ----------------------------------------------------------------------------
module imh_pos_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned SW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [SW-1:0] wslot_i,
  input  logic          wpres_i,
  input  logic [AW-1:0] raddr_i,
  output logic [SW-1:0] rslot_o,
  output logic          rpres_o
);

  logic [SW:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wslot_i, wpres_i};
    end
    {rslot_o, rpres_o} <= mem[raddr_i];
  end

endmodule

FILE: hdl/indexed_min_heap_core.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_core
// Indexed binary min-heap of (vertex, distance) with decrease-key.
// ----------------------------------------------------------------------------
// Usage:
//   req_i takes one word per operation: insert, extract minimum or
//   decrease key. rsp_o returns exactly one word per request, in order,
//   with status, the extracted pair (zero unless a good extract), the
//   entry count after the operation and an empty flag.
//   One operation is in flight at a time. Rejected requests answer
//   without a sift; insert and decrease sift up level by level and
//   extract sifts down level by level (one slot-memory read of both
//   children, then compare and write back). The sift loop through the
//   slot memory's registered read sets the worst case.
//   After reset a clearing pass sweeps the presence bits, one vertex a
//   cycle, with req_i not ready.
//   If the receiver stalls, the finished word waits in the output register
//   and the next request is still taken; its result is held back until
//   the output register frees.
// ----------------------------------------------------------------------------
module indexed_min_heap_core
  import imh_pkg::*;
#(
  parameter int unsigned VERTICES  = 1024,
  parameter int unsigned DIST_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  imh_req_if.sink   req_i,
  imh_rsp_if.source rsp_o
);

  localparam int unsigned VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int unsigned SW = VW;
  localparam int unsigned CW = $clog2(VERTICES + 1);
  localparam int unsigned DW = DIST_BITS;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_INS_CHK, S_DEC_CHK, S_DEC_CMP, S_EX_RD,
    S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_FIN, S_RESP
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       cnt_q;
  logic [SW-1:0]       at_q;
  logic [VW-1:0]       clr_q;
  logic [VW-1:0]       v_q, cur_v_q, mv_q;
  logic [DW-1:0]       key_q, cur_d_q, md_q;
  logic [STATUS_W-1:0] status_q;
  logic                rsp_valid_q;
  logic [STATUS_W-1:0] rsp_status_q;
  logic [VERTEX_W-1:0] rsp_vertex_q;
  logic [DISTREQ_W-1:0] rsp_dist_q;
  logic [COUNT_W-1:0]  rsp_count_q;
  logic                rsp_empty_q;

  // memory ports
  logic          s_we;
  logic [SW-1:0] s_waddr, s_ra, s_rb;
  logic [VW-1:0] s_wvert, s_rvert_a, s_rvert_b;
  logic [DW-1:0] s_wdist, s_rdist_a, s_rdist_b;
  logic          p_we, p_wpres, p_rpres;
  logic [VW-1:0] p_waddr, p_raddr;
  logic [SW-1:0] p_wslot, p_rslot;

  imh_slot_ram #(.DEPTH(VERTICES), .AW(SW), .VW(VW), .DW(DW)) u_slot_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wvert_i(s_wvert), .wdist_i(s_wdist),
    .raddr_a_i(s_ra), .raddr_b_i(s_rb),
    .rvert_a_o(s_rvert_a), .rdist_a_o(s_rdist_a),
    .rvert_b_o(s_rvert_b), .rdist_b_o(s_rdist_b)
  );

  imh_pos_ram #(.DEPTH(VERTICES), .AW(VW), .SW(SW)) u_pos_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wslot_i(p_wslot), .wpres_i(p_wpres),
    .raddr_i(p_raddr), .rslot_o(p_rslot), .rpres_o(p_rpres)
  );

  // heap index arithmetic, wide enough to hold 2*at+2
  logic [SW+1:0] left_w, right_w, cnt_w;
  logic [SW-1:0] parent;
  logic          vin_bad, lt_l, lt_r, going_up, going_down;
  logic [DW-1:0] best_d;
  logic [DW-1:0] key_in;

  assign left_w  = {1'b0, at_q, 1'b1};
  assign right_w = (SW+2)'({at_q, 1'b0}) + (SW+2)'(2);
  assign cnt_w   = (SW+2)'(cnt_q);
  assign parent  = SW'((at_q - 1'b1) >> 1);
  assign vin_bad = 32'(req_i.vertex) >= VERTICES;
  assign key_in  = DW'(req_i.dist_req);

  // sift-down choice: strict compares, left wins a tie
  assign lt_l   = (left_w < cnt_w) && (s_rdist_a < cur_d_q);
  assign best_d = lt_l ? s_rdist_a : cur_d_q;
  assign lt_r   = (right_w < cnt_w) && (s_rdist_b < best_d);
  assign going_up   = cur_d_q < s_rdist_a;
  assign going_down = lt_l || lt_r;

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    s_ra    = '0;
    s_rb    = SW'(cnt_q - 1'b1);
    p_raddr = VW'(req_i.vertex);
    s_we    = 1'b0;
    s_waddr = at_q;
    s_wvert = cur_v_q;
    s_wdist = cur_d_q;
    p_we    = 1'b0;
    p_waddr = cur_v_q;
    p_wslot = at_q;
    p_wpres = 1'b1;
    unique case (state_q)
      S_CLR: begin
        p_we    = 1'b1;
        p_waddr = clr_q;
        p_wpres = 1'b0;
      end
      S_DEC_CHK: s_ra = p_rslot;
      S_EX_RD: begin
        p_we    = 1'b1;
        p_waddr = s_rvert_a;
        p_wpres = 1'b0;
      end
      S_UP_RD: s_ra = parent;
      S_UP_CMP: begin
        if (going_up) begin
          s_we    = 1'b1;
          s_wvert = s_rvert_a;
          s_wdist = s_rdist_a;
          p_we    = 1'b1;
          p_waddr = s_rvert_a;
        end
      end
      S_DN_RD: begin
        s_ra = SW'(left_w);
        s_rb = SW'(right_w);
      end
      S_DN_CMP: begin
        if (going_down) begin
          s_we    = 1'b1;
          s_wvert = lt_r ? s_rvert_b : s_rvert_a;
          s_wdist = lt_r ? s_rdist_b : s_rdist_a;
          p_we    = 1'b1;
          p_waddr = lt_r ? s_rvert_b : s_rvert_a;
        end
      end
      S_FIN: begin
        s_we = 1'b1;
        p_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      // S_RESP reloads the output register itself
      if (rsp_valid_q && rsp_o.ready && (state_q != S_RESP)) rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == VW'(VERTICES - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req_i.valid) begin
            v_q      <= VW'(req_i.vertex);
            key_q    <= key_in;
            mv_q     <= '0;
            md_q     <= '0;
            status_q <= ST_OK;
            state_q  <= S_RESP;
            unique case (req_i.action)
              ACT_INSERT: begin
                if (32'(cnt_q) >= VERTICES) status_q <= ST_FULL;
                else if (vin_bad)           status_q <= ST_ABSENT;
                else                        state_q  <= S_INS_CHK;
              end
              ACT_EXTRACT: begin
                if (cnt_q == '0) status_q <= ST_EMPTY;
                else             state_q  <= S_EX_RD;
              end
              ACT_DECREASE: begin
                if (vin_bad) status_q <= ST_ABSENT;
                else         state_q  <= S_DEC_CHK;
              end
              default: ;
            endcase
          end
        end
        S_INS_CHK: begin
          if (p_rpres) begin
            status_q <= ST_PRESENT;
            state_q  <= S_RESP;
          end else begin
            at_q    <= SW'(cnt_q);
            cnt_q   <= cnt_q + 1'b1;
            cur_v_q <= v_q;
            cur_d_q <= key_q;
            state_q <= S_UP_RD;
          end
        end
        S_DEC_CHK: begin
          if (!p_rpres) begin
            status_q <= ST_ABSENT;
            state_q  <= S_RESP;
          end else begin
            at_q    <= p_rslot;
            state_q <= S_DEC_CMP;
          end
        end
        S_DEC_CMP: begin
          cur_v_q <= v_q;
          cur_d_q <= key_q;
          if ((CW'(at_q) < cnt_q) && (key_q < s_rdist_a)) state_q <= S_UP_RD;
          else                                              state_q <= S_RESP;
        end
        S_EX_RD: begin
          mv_q    <= s_rvert_a;
          md_q    <= s_rdist_a;
          cnt_q   <= cnt_q - 1'b1;
          cur_v_q <= s_rvert_b;
          cur_d_q <= s_rdist_b;
          at_q    <= '0;
          // the root was the only entry: nothing to move
          if (cnt_q == CW'(1)) state_q <= S_RESP;
          else                 state_q <= S_DN_RD;
        end
        S_UP_RD: state_q <= (at_q == '0) ? S_FIN : S_UP_CMP;
        S_UP_CMP: begin
          if (going_up) begin
            at_q    <= parent;
            state_q <= S_UP_RD;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_DN_RD: state_q <= (left_w >= cnt_w) ? S_FIN : S_DN_CMP;
        S_DN_CMP: begin
          if (going_down) begin
            at_q    <= lt_r ? SW'(right_w) : SW'(left_w);
            state_q <= S_DN_RD;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FIN: state_q <= S_RESP;
        S_RESP: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= status_q;
            rsp_vertex_q <= VERTEX_W'(mv_q);
            rsp_dist_q   <= DISTREQ_W'(md_q);
            rsp_count_q  <= COUNT_W'(cnt_q);
            rsp_empty_q  <= (cnt_q == '0);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.min_vertex = rsp_vertex_q;
  assign rsp_o.min_dist   = rsp_dist_q;
  assign rsp_o.count      = rsp_count_q;
  assign rsp_o.is_empty   = rsp_empty_q;

  // entry count never passes capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(cnt_q) <= VERTICES)
    else $error("entry count above capacity");

  // result word's empty flag agrees with its count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.is_empty == (rsp_o.count == '0)))
    else $error("empty flag disagrees with count");

  // no request taken during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !req_i.ready)
    else $error("request accepted while clearing");

  // a sift-down step only moves to a child inside the heap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DN_CMP) |-> (left_w < cnt_w))
    else $error("sift-down beyond last entry");

endmodule
